// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the frame detector RTL.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define JBFD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define JBFD_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/jbfd_pkg.sv -----
// Types and marker constants for the baseline JPEG frame detector.
// No dependencies.
package jbfd_pkg;

  typedef enum logic [2:0] {
    PH_START0 = 3'd0,
    PH_START1 = 3'd1,
    PH_HUNT   = 3'd2,
    PH_MARKER = 3'd3,
    PH_LENHI  = 3'd4,
    PH_LENLO  = 3'd5,
    PH_SKIP   = 3'd6
  } phase_e;

  localparam logic [7:0] MRK_PREFIX    = 8'hFF;
  localparam logic [7:0] MRK_SOI       = 8'hD8;
  localparam logic [7:0] MRK_SOS       = 8'hDA;
  localparam logic [7:0] MRK_EOI       = 8'hD9;
  localparam logic [7:0] MRK_SOF0      = 8'hC0;
  localparam logic [7:0] MRK_SOF_FIRST = 8'hC1;
  localparam logic [7:0] MRK_SOF_LAST  = 8'hCF;
  localparam logic [7:0] MRK_DHT       = 8'hC4;
  localparam logic [7:0] MRK_JPG       = 8'hC8;
  localparam logic [7:0] MRK_DAC       = 8'hCC;
  localparam logic [7:0] MRK_RST_FIRST = 8'hD0;
  localparam logic [7:0] MRK_RST_LAST  = 8'hD7;

  localparam logic [15:0] SEG_LEN_MIN = 16'd2;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       eos;
  } in_word_t;

  typedef struct packed {
    logic valid;
    logic verdict;
  } scan_res_t;

  typedef struct packed {
    logic verdict_given;
    logic in_skip;
    logic skip_zero;
  } scan_stat_t;

endpackage

// ----- hdl/jbfd_in_stage.sv -----
// Input register of the frame detector: holds one accepted byte.
// Depends on jbfd_pkg.
module jbfd_in_stage import jbfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_stream_i,
  input  logic       adv_i,
  output logic       in_stall_o,
  output in_word_t   word_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       eos_q;
  logic       load;

  assign in_stall_o = valid_q && !adv_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    priority if (load) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_byte_i;
      eos_q  <= end_of_stream_i;
    end
  end

  assign word_o = '{valid: valid_q, data: data_q, eos: eos_q};

endmodule

// ----- hdl/jbfd_scan.sv -----
// Marker scanner: stream state and the per-byte decision.
// Depends on jbfd_pkg.
module jbfd_scan import jbfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_word_t   word_i,
  input  logic       fire_i,
  output scan_res_t  res_o,
  output scan_stat_t stat_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  lenhi_q, lenhi_d;
  logic [15:0] skip_q, skip_d;
  logic        given_q, given_d;

  logic        found;
  logic        verdict;
  logic [7:0]  b;
  logic [15:0] seg_len;
  logic [15:0] skip_dec;
  logic        other_sof;
  logic        restart;

  assign b        = word_i.data;
  assign seg_len  = {lenhi_q, b};
  assign skip_dec = skip_q - 16'd1;
  assign other_sof = (b >= MRK_SOF_FIRST) && (b <= MRK_SOF_LAST) &&
                     (b != MRK_DHT) && (b != MRK_JPG) && (b != MRK_DAC);
  assign restart  = (b >= MRK_RST_FIRST) && (b <= MRK_RST_LAST);

  always_comb begin
    phase_d = phase_q;
    lenhi_d = lenhi_q;
    skip_d  = skip_q;
    given_d = given_q;
    found   = 1'b0;
    verdict = 1'b0;
    if (fire_i) begin
      if (given_q) begin
        // drop late bytes; the flagged one starts a new stream
        if (word_i.eos) begin
          phase_d = PH_START0;
          lenhi_d = '0;
          skip_d  = '0;
          given_d = 1'b0;
        end
      end else begin
        unique case (phase_q)
          PH_START0: begin
            if (b != MRK_PREFIX) begin
              found = 1'b1;
            end else begin
              phase_d = PH_START1;
            end
          end
          PH_START1: begin
            if (b != MRK_SOI) begin
              found = 1'b1;
            end else begin
              phase_d = PH_HUNT;
            end
          end
          PH_MARKER: begin
            priority if (b == MRK_PREFIX) begin
              phase_d = PH_MARKER;
            end else if (b == MRK_SOS || b == MRK_EOI) begin
              found = 1'b1;
            end else if (b == MRK_SOF0) begin
              found   = 1'b1;
              verdict = 1'b1;
            end else if (other_sof) begin
              found = 1'b1;
            end else if (restart) begin
              phase_d = PH_HUNT;
            end else begin
              phase_d = PH_LENHI;
            end
          end
          PH_LENHI: begin
            lenhi_d = b;
            phase_d = PH_LENLO;
          end
          PH_LENLO: begin
            priority if (seg_len < SEG_LEN_MIN) begin
              found = 1'b1;
            end else if (seg_len == SEG_LEN_MIN) begin
              phase_d = PH_HUNT;
            end else begin
              skip_d  = seg_len - SEG_LEN_MIN;
              phase_d = PH_SKIP;
            end
          end
          PH_SKIP: begin
            skip_d = skip_dec;
            if (skip_dec == '0) begin
              phase_d = PH_HUNT;
            end
          end
          default: begin
            if (b == MRK_PREFIX) begin
              phase_d = PH_MARKER;
            end
          end
        endcase
        // stream ended before any decision
        if (!found && word_i.eos) begin
          found   = 1'b1;
          verdict = 1'b0;
        end
        if (found) begin
          if (word_i.eos) begin
            phase_d = PH_START0;
            lenhi_d = '0;
            skip_d  = '0;
            given_d = 1'b0;
          end else begin
            given_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START0;
      lenhi_q <= '0;
      skip_q  <= '0;
      given_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      lenhi_q <= lenhi_d;
      skip_q  <= skip_d;
      given_q <= given_d;
    end
  end

  assign res_o  = '{valid: found, verdict: verdict};
  assign stat_o = '{verdict_given: given_q,
                    in_skip:       (phase_q == PH_SKIP),
                    skip_zero:     (skip_q == '0)};

endmodule

// ----- hdl/jbfd_out_stage.sv -----
// Result register of the frame detector: holds one verdict word.
// Depends on jbfd_pkg.
module jbfd_out_stage import jbfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  scan_res_t res_i,
  input  logic      out_stall_i,
  output logic      adv_o,
  output logic      out_valid_o,
  output logic      is_baseline_o
);

  logic valid_q, valid_d;
  logic verdict_q;

  // advance when the register is empty or its word is taken this cycle
  assign adv_o   = !valid_q || !out_stall_i;
  assign valid_d = adv_o ? res_i.valid : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && res_i.valid) begin
      verdict_q <= res_i.verdict;
    end
  end

  assign out_valid_o   = valid_q;
  assign is_baseline_o = verdict_q;

endmodule

// ----- hdl/jpeg_baseline_frame_detector_top.sv -----
// Baseline JPEG frame detector.
// Input side: one stream byte per word (data_byte_i), end_of_stream_i flags
// the final byte. A word is taken on a clock edge with in_valid_i high and
// in_stall_o low.
// Output side: at most one word per stream, is_baseline_o = 1 when an SOF0
// marker is met before SOS, EOI or another frame type; 0 otherwise (bad
// start, short segment length, early end). A word is taken on an edge with
// out_valid_o high and out_stall_i low.
// A byte that decides the verdict is decoded from the input register into
// the result register, which drives out_valid_o.
// Throughput: one byte per cycle while in_stall_o is low; the scanner does a single
// state update per byte, segment payloads are counted down one byte at a time.
// Stall: while the result register holds an untaken verdict and the input
// register is full, in_stall_o rises; bytes that give no verdict still drain
// whenever the result register is empty or being taken.
// Reset: rst_ni clears the valid flags and the scanner state; the block then
// expects FF D8. The byte flagged end_of_stream_i also returns the scanner to that state.
// Depends on jbfd_pkg, jbfd_in_stage, jbfd_scan, jbfd_out_stage.
`include "assert_macros.svh"

module jpeg_baseline_frame_detector_top import jbfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_stream_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_baseline_o
);

  in_word_t   word;
  scan_res_t  res;
  scan_stat_t stat;
  logic       adv;
  logic       fire;

  assign fire = word.valid && adv;

  jbfd_in_stage u_in_stage (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .data_byte_i     (data_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .adv_i           (adv),
    .in_stall_o      (in_stall_o),
    .word_o          (word)
  );

  jbfd_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .word_i (word),
    .fire_i (fire),
    .res_o  (res),
    .stat_o (stat)
  );

  jbfd_out_stage u_out_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_i         (res),
    .out_stall_i   (out_stall_i),
    .adv_o         (adv),
    .out_valid_o   (out_valid_o),
    .is_baseline_o (is_baseline_o)
  );

  `JBFD_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o,
                   out_valid_o && out_stall_i, "input stalled with result side free")
  `JBFD_ASSERT_IMP(a_one_verdict, clk_i, rst_ni, res.valid, !stat.verdict_given,
                   "second verdict in one stream")
  `JBFD_ASSERT_IMP(a_skip_count, clk_i, rst_ni, stat.in_skip, !stat.skip_zero,
                   "payload skip with zero count")
  `JBFD_ASSERT_NXT(a_verdict_lands, clk_i, rst_ni, res.valid, out_valid_o,
                   "verdict did not reach the result register")

endmodule

// ----- tb/jpeg_baseline_frame_detector_checker.sv -----
// Scoreboard for the baseline JPEG frame detector: watches both channels,
// predicts one verdict per stream and compares the output words in order.
// Depends on jbfd_pkg for the scan phases and marker codes.
`timescale 1ns / 1ps

module jpeg_baseline_frame_detector_checker import jbfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_stream_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       is_baseline_i,
  input  logic       drain_check_i,
  output int         mismatches_o,
  output int         verdicts_pending_o
);

  phase_e      scan_phase;
  logic [7:0]  len_hi;
  logic [15:0] skip_left;
  logic        verdict_sent;

  logic        expected_verdicts[$];
  int          mismatch_count = 0;
  int          pending_count = 0;
  bit          drain_checked = 1'b0;

  assign mismatches_o       = mismatch_count;
  assign verdicts_pending_o = pending_count;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic clear_scan();
    scan_phase   = PH_START0;
    len_hi       = 8'h00;
    skip_left    = 16'h0000;
    verdict_sent = 1'b0;
  endtask

  // Advance the scan by one byte; decided is set when the byte settles the verdict.
  task automatic scan_byte(input logic [7:0] b, output logic decided, output logic verdict);
    logic [15:0] seg_len;
    decided = 1'b0;
    verdict = 1'b0;
    seg_len = {len_hi, b};
    case (scan_phase)
      PH_START0: begin
        if (b != MRK_PREFIX) decided = 1'b1;
        else scan_phase = PH_START1;
      end
      PH_START1: begin
        if (b != MRK_SOI) decided = 1'b1;
        else scan_phase = PH_HUNT;
      end
      PH_MARKER: begin
        // further prefix bytes are fill: stay here
        if (b != MRK_PREFIX) begin
          if (b == MRK_SOS || b == MRK_EOI) begin
            decided = 1'b1;
          end else if (b == MRK_SOF0) begin
            decided = 1'b1;
            verdict = 1'b1;
          end else if (b >= MRK_SOF_FIRST && b <= MRK_SOF_LAST && b != MRK_DHT &&
                       b != MRK_JPG && b != MRK_DAC) begin
            decided = 1'b1;
          end else if (b >= MRK_RST_FIRST && b <= MRK_RST_LAST) begin
            scan_phase = PH_HUNT;
          end else begin
            scan_phase = PH_LENHI;
          end
        end
      end
      PH_LENHI: begin
        len_hi     = b;
        scan_phase = PH_LENLO;
      end
      PH_LENLO: begin
        if (seg_len < SEG_LEN_MIN) begin
          decided = 1'b1;
        end else if (seg_len == SEG_LEN_MIN) begin
          scan_phase = PH_HUNT;
        end else begin
          skip_left  = seg_len - SEG_LEN_MIN;
          scan_phase = PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == 16'd0) scan_phase = PH_HUNT;
      end
      default: begin
        if (b == MRK_PREFIX) scan_phase = PH_MARKER;
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic decided;
    logic verdict;
    logic want;
    if (!rst_ni) begin
      clear_scan();
      expected_verdicts.delete();
    end else begin
      // check the output first: a word taken now cannot come from a byte taken now
      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("verdict %0b with none expected", is_baseline_i));
        end else begin
          want = expected_verdicts.pop_front();
          if (is_baseline_i !== want)
            report_mismatch($sformatf("is_baseline %0b, expected %0b", is_baseline_i, want));
        end
      end
      if (in_valid_i === 1'b1 && in_stall_i === 1'b0) begin
        if (verdict_sent) begin
          // drop late bytes; the flagged one restarts the scan
          if (end_of_stream_i) clear_scan();
        end else begin
          scan_byte(data_byte_i, decided, verdict);
          if (decided || end_of_stream_i) begin
            expected_verdicts.push_back(decided ? verdict : 1'b0);
            if (end_of_stream_i) clear_scan();
            else verdict_sent = 1'b1;
          end
        end
      end
      if (drain_check_i && !drain_checked) begin
        drain_checked = 1'b1;
        if (expected_verdicts.size() != 0)
          report_mismatch($sformatf("%0d verdicts never arrived", expected_verdicts.size()));
      end
    end
    pending_count = expected_verdicts.size();
  end

endmodule

// ----- tb/jpeg_baseline_frame_detector_top_tb.sv -----
// Testbench top for the baseline JPEG frame detector: builds byte streams,
// drives them with random gaps and output stalls, and gives the verdict.
// Depends on jbfd_pkg, jpeg_baseline_frame_detector_top and the checker module.
`timescale 1ns / 1ps

module jpeg_baseline_frame_detector_top_tb;
  import jbfd_pkg::*;

  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 11;
  localparam int RANDOM_ITEMS  = 1600;
  localparam int QUIET_TAIL    = 250;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       in_valid_i      = 1'b0;
  logic [7:0] data_byte_i     = 8'h00;
  logic       end_of_stream_i = 1'b0;
  logic       out_stall_i     = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       is_baseline_o;

  logic       in_taken    = 1'b0;
  logic       drain_check = 1'b0;
  bit         gaps_on     = 1'b1;
  bit         stream_calm = 1'b0;
  int         stall_left  = 0;
  int         calm_left   = 0;
  int         cycle_count = 0;
  int         random_sent = 0;
  int         mismatches;
  int         verdicts_pending;
  logic [7:0] stream_bytes[$];

  jpeg_baseline_frame_detector_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .end_of_stream_i(end_of_stream_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .is_baseline_o  (is_baseline_o)
  );

  jpeg_baseline_frame_detector_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .data_byte_i       (data_byte_i),
    .end_of_stream_i   (end_of_stream_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .is_baseline_i     (is_baseline_o),
    .drain_check_i     (drain_check),
    .mismatches_o      (mismatches),
    .verdicts_pending_o(verdicts_pending)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    in_taken    <= in_valid_i && !in_stall_o;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Output stall: bursts of random length, with calm stretches between.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (calm_left > 0) begin
      out_stall_i <= 1'b0;
      calm_left   <= calm_left - 1;
    end else if (gaps_on && $urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 2);
    end else begin
      out_stall_i <= 1'b0;
      if ($urandom_range(0, 29) == 0) calm_left <= $urandom_range(10, 40);
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_byte(input logic [7:0] value, input logic last);
    if (gaps_on && !stream_calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= value;
    end_of_stream_i <= last;
    @(negedge clk_i);
    while (!in_taken) @(negedge clk_i);
  endtask

  task automatic send_stream();
    stream_calm = ($urandom_range(0, 3) == 0);
    foreach (stream_bytes[i]) send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
  endtask

  // Hold the input until every predicted verdict has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (verdicts_pending != 0) @(negedge clk_i);
  endtask

  // Mostly well-formed streams with random segments, plus noise and bad starts.
  task automatic build_stream();
    int         kind;
    int         ending;
    int         seg_len;
    logic [7:0] code;
    stream_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      repeat ($urandom_range(1, 6)) stream_bytes.push_back(8'($urandom));
      return;
    end
    if (kind < 12) begin
      if ($urandom_range(0, 1) == 0) begin
        do code = 8'($urandom); while (code == MRK_PREFIX);
        stream_bytes.push_back(code);
      end else begin
        do code = 8'($urandom); while (code == MRK_SOI);
        stream_bytes.push_back(MRK_PREFIX);
        stream_bytes.push_back(code);
      end
      repeat ($urandom_range(0, 2)) stream_bytes.push_back(8'($urandom));
      return;
    end
    stream_bytes.push_back(MRK_PREFIX);
    stream_bytes.push_back(MRK_SOI);
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 5) == 0) stream_bytes.push_back(8'($urandom));
      stream_bytes.push_back(MRK_PREFIX);
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
        stream_bytes.push_back(MRK_PREFIX);
      if ($urandom_range(0, 4) == 0) begin
        stream_bytes.push_back(MRK_RST_FIRST + 8'($urandom_range(0, 7)));
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 3))
            0:       code = MRK_DHT;
            1:       code = MRK_JPG;
            2:       code = MRK_DAC;
            default: code = MRK_SOI;
          endcase
        end else begin
          do code = 8'($urandom);
          while (code == MRK_PREFIX || code == MRK_SOF0 || code == MRK_SOS ||
                 code == MRK_EOI || (code >= MRK_SOF_FIRST && code <= MRK_SOF_LAST) ||
                 (code >= MRK_RST_FIRST && code <= MRK_RST_LAST));
        end
        stream_bytes.push_back(code);
        seg_len = ($urandom_range(0, 19) == 0) ? $urandom_range(3, 600) : $urandom_range(2, 9);
        stream_bytes.push_back(seg_len[15:8]);
        stream_bytes.push_back(seg_len[7:0]);
        repeat (seg_len - 2) stream_bytes.push_back(8'($urandom));
      end
    end
    ending = $urandom_range(0, 99);
    if (ending < 75) begin
      stream_bytes.push_back(MRK_PREFIX);
      if (ending < 35) begin
        repeat ($urandom_range(0, 2)) stream_bytes.push_back(MRK_PREFIX);
        stream_bytes.push_back(MRK_SOF0);
      end else if (ending < 45) begin
        stream_bytes.push_back(MRK_SOS);
      end else if (ending < 53) begin
        stream_bytes.push_back(MRK_EOI);
      end else if (ending < 65) begin
        do code = MRK_SOF_FIRST + 8'($urandom_range(0, 14));
        while (code == MRK_DHT || code == MRK_JPG || code == MRK_DAC);
        stream_bytes.push_back(code);
      end else begin
        // short segment length
        stream_bytes.push_back(8'hE0 + 8'($urandom_range(0, 15)));
        stream_bytes.push_back(8'h00);
        stream_bytes.push_back(8'($urandom_range(0, 1)));
      end
      repeat ($urandom_range(0, 3)) stream_bytes.push_back(8'($urandom));
    end else begin
      // stream cut short somewhere in a marker or segment
      case ($urandom_range(0, 3))
        0: ;
        1: stream_bytes.push_back(MRK_PREFIX);
        2: begin
          stream_bytes.push_back(MRK_PREFIX);
          stream_bytes.push_back(8'hE0 + 8'($urandom_range(0, 15)));
        end
        default: begin
          stream_bytes.push_back(MRK_PREFIX);
          stream_bytes.push_back(8'hE0 + 8'($urandom_range(0, 15)));
          stream_bytes.push_back(8'($urandom));
          stream_bytes.push_back(8'($urandom));
          repeat ($urandom_range(0, 3)) stream_bytes.push_back(8'($urandom));
        end
      endcase
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // bad first byte, flagged at once
    stream_bytes = '{8'h00};
    send_stream();
    // bad second byte, then a late byte carrying the flag
    stream_bytes = '{8'hFF, 8'h01, 8'hFE};
    send_stream();
    // fill, restart marker, length of two, SOF0 decided on the flagged byte
    stream_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hFF, 8'hD7, 8'hFF, 8'hC4, 8'h00, 8'h02,
                     8'hFF, 8'hC0};
    send_stream();
    // short length, then a late byte
    stream_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h01, 8'h80};
    send_stream();
    // early end inside a segment payload
    stream_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hDB, 8'h00, 8'h05, 8'hFF};
    send_stream();
    // scan start, then another frame type
    stream_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hDA};
    send_stream();
    stream_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hC2, 8'h7F};
    send_stream();
    wait_drained();

    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent > RANDOM_ITEMS - QUIET_TAIL) gaps_on = 1'b0;
      if (gaps_on && $urandom_range(0, 24) == 0) wait_drained();
      build_stream();
      send_stream();
      random_sent += stream_bytes.size();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    drain_check <= 1'b1;
    repeat (2) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
